// ===== design/lzd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LZ token stream decoder
package lzd_pkg;
	localparam int HISTORY_DEPTH_DEF = 16384;
	localparam int WORD_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int DOC_SIZE_W = 15;
	localparam int CFG_INDEX_W = 1;
	localparam int WORD_W = 64;
	localparam int COUNT_W = 4;
	localparam int LANE_W = 3;

	localparam logic [DOC_SIZE_W-1:0] DOC_SIZE_RESET = 15'd16384;
	localparam logic [CFG_INDEX_W-1:0] REG_DOCUMENT_SIZE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_RAW_MODE = 1'b1;

	localparam logic [7:0] TOKEN_MATCH_BIT = 8'h80;
	localparam logic [7:0] TOKEN_LEN_MASK = 8'h7F;
	localparam logic [7:0] MATCH_MIN_LEN = 8'd4;

	typedef enum logic [1:0] {
		PH_TOKEN,
		PH_LITERAL,
		PH_OFF_LO,
		PH_OFF_HI
	} phase_t;

	typedef enum logic {
		BK_IDLE,
		BK_COPY
	} back_state_t;

	typedef enum logic [1:0] {
		CMD_END,
		CMD_LIT,
		CMD_MATCH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] lit_byte;
		logic [7:0] len;
		logic       fin;
		logic       status;
	} cmd_t;
endpackage

// ===== design/lzd_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read
module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== design/lzd_fifo.sv =====
`timescale 1ns / 1ps
// Small show-ahead command queue between parser and copy engine
module lzd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (fill_q == NW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== design/lzd_front.sv =====
`timescale 1ns / 1ps
// Token parser: takes payload bytes, tracks document state, emits copy commands
module lzd_front
	import lzd_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(HISTORY_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             code_byte,
	input  logic                   final_byte,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DOC_SIZE_W-1:0]  cfg_data,
	input  logic                   q_full,
	output logic                   push,
	output cmd_t                   push_cmd,
	output logic [AW-1:0]          push_src,
	output logic [AW-1:0]          push_dst
);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int LW = (CW > DOC_SIZE_W) ? CW : DOC_SIZE_W;
	localparam int OW = (CW > 16) ? CW : 16;

	phase_t                phase_q, phase_d;
	logic [7:0]            pend_q, pend_d;
	logic [7:0]            offlo_q, offlo_d;
	logic [CW-1:0]         oc_q, oc_d;
	logic                  err_q, err_d;
	logic [DOC_SIZE_W-1:0] doc_size_q;
	logic                  raw_q;

	logic                  accept;
	logic [LW-1:0]         size_ext;
	logic [LW-1:0]         lim_w;
	logic [CW-1:0]         lim;
	logic [CW-1:0]         room;
	logic [7:0]            lit_len;
	logic [7:0]            pend_dec;
	logic [15:0]           off;
	logic [OW-1:0]         src_w;
	logic                  lit_room_ok;
	logic                  match_room_ok;
	logic                  has_out;
	cmd_kind_t             kind;
	logic                  doc_ok;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	assign size_ext = LW'(doc_size_q);
	assign lim_w    = (size_ext > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : size_ext;
	assign lim      = CW'(lim_w);
	assign room     = lim - oc_q;
	assign lit_len  = {1'b0, code_byte[6:0]} + 8'd1;
	assign pend_dec = (pend_q != 8'd0) ? pend_q - 8'd1 : 8'd0;
	assign off      = {code_byte, offlo_q};
	assign src_w    = OW'(oc_q) - OW'(off);

	assign lit_room_ok   = (oc_q > lim) || (CW'(lit_len) <= room);
	assign match_room_ok = (oc_q > lim) || (CW'(pend_q) <= room);

	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		offlo_d = offlo_q;
		oc_d    = oc_q;
		err_d   = err_q;
		has_out = 1'b0;
		kind    = CMD_END;
		if (err_q) begin
			has_out = 1'b0;
		end else if (raw_q) begin
			if (oc_q < lim) begin
				has_out = 1'b1;
				kind    = CMD_LIT;
				oc_d    = oc_q + CW'(1);
			end else begin
				err_d = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_TOKEN: begin
					if (oc_q >= lim) begin
						err_d = 1'b1;
					end else if ((code_byte & TOKEN_MATCH_BIT) != 8'd0) begin
						pend_d  = (code_byte & TOKEN_LEN_MASK) + MATCH_MIN_LEN;
						phase_d = PH_OFF_LO;
					end else if (!lit_room_ok) begin
						err_d = 1'b1;
					end else begin
						pend_d  = lit_len;
						phase_d = PH_LITERAL;
					end
				end
				PH_LITERAL: begin
					if (oc_q < lim) begin
						has_out = 1'b1;
						kind    = CMD_LIT;
						oc_d    = oc_q + CW'(1);
					end
					pend_d = pend_dec;
					if (pend_dec == 8'd0) begin
						phase_d = PH_TOKEN;
					end
				end
				PH_OFF_LO: begin
					offlo_d = code_byte;
					phase_d = PH_OFF_HI;
				end
				PH_OFF_HI: begin
					if (off == 16'd0 || OW'(off) > OW'(oc_q) || !match_room_ok) begin
						err_d = 1'b1;
					end else begin
						has_out = 1'b1;
						kind    = CMD_MATCH;
						oc_d    = oc_q + CW'(pend_q);
						pend_d  = 8'd0;
					end
					phase_d = PH_TOKEN;
				end
			endcase
		end
	end

	assign doc_ok = !err_d && (phase_d == PH_TOKEN) && (oc_d == lim);

	assign push              = accept && (has_out || final_byte);
	assign push_cmd.kind     = has_out ? kind : CMD_END;
	assign push_cmd.lit_byte = code_byte;
	assign push_cmd.len      = pend_q;
	assign push_cmd.fin      = final_byte;
	assign push_cmd.status   = !doc_ok;
	assign push_src          = src_w[AW-1:0];
	assign push_dst          = oc_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TOKEN;
			pend_q     <= 8'd0;
			offlo_q    <= 8'd0;
			oc_q       <= '0;
			err_q      <= 1'b0;
			doc_size_q <= DOC_SIZE_RESET;
			raw_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_DOCUMENT_SIZE: doc_size_q <= cfg_data;
					REG_RAW_MODE:      raw_q      <= cfg_data[0];
				endcase
			end
			if (accept) begin
				if (final_byte) begin
					phase_q <= PH_TOKEN;
					pend_q  <= 8'd0;
					offlo_q <= 8'd0;
					oc_q    <= '0;
					err_q   <= 1'b0;
				end else begin
					phase_q <= phase_d;
					pend_q  <= pend_d;
					offlo_q <= offlo_d;
					oc_q    <= oc_d;
					err_q   <= err_d;
				end
			end
		end
	end
endmodule

// ===== design/lzd_back.sv =====
`timescale 1ns / 1ps
// Copy engine: runs commands against the history RAM and packs output words
module lzd_back
	import lzd_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int WORD_BYTES = WORD_BYTES_DEF,
	localparam int AW = $clog2(HISTORY_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  cmd_t               q_cmd,
	input  logic [AW-1:0]      q_src,
	input  logic [AW-1:0]      q_dst,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [WORD_W-1:0]  data_word,
	output logic [COUNT_W-1:0] byte_count,
	output logic               run_last,
	output logic               document_end,
	output logic               decode_status
);
	back_state_t        state_q, state_d;
	logic [AW-1:0]      src_q, src_d;
	logic [AW-1:0]      dst_q, dst_d;
	logic [7:0]         rem_q, rem_d;
	logic               fin_q, fin_d;
	logic               status_q, status_d;

	logic               adv;
	logic               issue;
	logic               iss_has_byte;
	logic               iss_ram;
	logic               iss_last;
	logic               iss_fin;
	logic               iss_status;
	logic [AW-1:0]      iss_dst;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [7:0]         rd_data;

	logic               v_s1;
	logic               has_byte_s1;
	logic               ram_s1;
	logic [7:0]         lit_s1;
	logic [AW-1:0]      dst_s1;
	logic               last_s1;
	logic               fin_s1;
	logic               status_s1;
	logic               hit_s1;
	logic [7:0]         fwd_s1;

	logic [WORD_W-1:0]  acc_q;
	logic [LANE_W-1:0]  lane_q;
	logic               out_valid_q;

	logic [7:0]         b_byte;
	logic               we;
	logic [WORD_W-1:0]  lane_word;
	logic [WORD_W-1:0]  acc_next;
	logic [COUNT_W-1:0] cnt_next;
	logic               emit;

	assign adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		src_d        = src_q;
		dst_d        = dst_q;
		rem_d        = rem_q;
		fin_d        = fin_q;
		status_d     = status_q;
		q_pop        = 1'b0;
		issue        = 1'b0;
		iss_has_byte = 1'b0;
		iss_ram      = 1'b0;
		iss_last     = 1'b0;
		iss_fin      = q_cmd.fin;
		iss_status   = q_cmd.status;
		iss_dst      = q_dst;
		rd_en        = 1'b0;
		rd_addr      = q_src;
		unique case (state_q)
			BK_IDLE: begin
				if (adv && !q_empty) begin
					q_pop = 1'b1;
					issue = 1'b1;
					unique case (q_cmd.kind)
						CMD_LIT: begin
							iss_has_byte = 1'b1;
							iss_last     = 1'b1;
						end
						CMD_MATCH: begin
							iss_has_byte = 1'b1;
							iss_ram      = 1'b1;
							rd_en        = 1'b1;
							iss_last     = (q_cmd.len == 8'd1);
							if (q_cmd.len != 8'd1) begin
								state_d  = BK_COPY;
								src_d    = q_src + AW'(1);
								dst_d    = q_dst + AW'(1);
								rem_d    = q_cmd.len - 8'd1;
								fin_d    = q_cmd.fin;
								status_d = q_cmd.status;
							end
						end
						default: begin
							iss_last = 1'b1;
						end
					endcase
				end
			end
			BK_COPY: begin
				if (adv) begin
					issue        = 1'b1;
					iss_has_byte = 1'b1;
					iss_ram      = 1'b1;
					iss_last     = (rem_q == 8'd1);
					iss_fin      = fin_q;
					iss_status   = status_q;
					iss_dst      = dst_q;
					rd_en        = 1'b1;
					rd_addr      = src_q;
					src_d        = src_q + AW'(1);
					dst_d        = dst_q + AW'(1);
					rem_d        = rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						state_d = BK_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		src_q    <= src_d;
		dst_q    <= dst_d;
		rem_q    <= rem_d;
		fin_q    <= fin_d;
		status_q <= status_d;
	end

	// byte currently being written may be the one read this cycle (offset one)
	assign b_byte    = ram_s1 ? (hit_s1 ? fwd_s1 : rd_data) : lit_s1;
	assign we        = adv && v_s1 && has_byte_s1;
	assign lane_word = WORD_W'(b_byte) << {lane_q, 3'b000};
	assign acc_next  = has_byte_s1 ? (acc_q | lane_word) : acc_q;
	assign cnt_next  = COUNT_W'(lane_q) + COUNT_W'(has_byte_s1);
	assign emit      = last_s1 || (lane_q == LANE_W'(WORD_BYTES - 1));

	lzd_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk    (clk),
		.wr_en  (we),
		.wr_addr(dst_s1),
		.wr_data(b_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			acc_q       <= '0;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			out_valid_q <= v_s1 && emit;
			if (v_s1) begin
				if (emit) begin
					acc_q  <= '0;
					lane_q <= '0;
				end else begin
					acc_q  <= acc_next;
					lane_q <= lane_q + LANE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			has_byte_s1 <= iss_has_byte;
			ram_s1      <= iss_ram;
			lit_s1      <= q_cmd.lit_byte;
			dst_s1      <= iss_dst;
			last_s1     <= iss_last;
			fin_s1      <= iss_fin;
			status_s1   <= iss_status;
			hit_s1      <= we && (dst_s1 == rd_addr);
			fwd_s1      <= b_byte;
			if (v_s1 && emit) begin
				data_word     <= acc_next;
				byte_count    <= cnt_next;
				run_last      <= last_s1;
				document_end  <= last_s1 && fin_s1;
				decode_status <= last_s1 && fin_s1 && status_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== design/lz_token_stream_decoder.sv =====
`timescale 1ns / 1ps
// LZ token stream decoder: top level joining parser, command queue and copy engine.
// Each accepted byte's command passes through the command queue, the copy engine's stage-1
// registers and the output register before its word is valid.
// Throughput: one payload byte per cycle while in_stall is low; a match of L bytes holds the copy
// engine for one history RAM read per byte, and input stalls once the 4-entry queue fills.
// Reset (arst_n low) clears parser state, registers to defaults and the output valid;
// history RAM contents are undefined until written.
module lz_token_stream_decoder
	import lzd_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int WORD_BYTES = WORD_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             code_byte,
	input  logic                   final_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [WORD_W-1:0]      data_word,
	output logic [COUNT_W-1:0]     byte_count,
	output logic                   run_last,
	output logic                   document_end,
	output logic                   decode_status,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DOC_SIZE_W-1:0]  cfg_data
);
	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int QW = $bits(cmd_t) + 2 * AW;

	logic          push;
	cmd_t          push_cmd;
	logic [AW-1:0] push_src;
	logic [AW-1:0] push_dst;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_data;
	cmd_t          q_cmd;
	logic [AW-1:0] q_src;
	logic [AW-1:0] q_dst;

	lzd_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_byte (code_byte),
		.final_byte(final_byte),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_src  (push_src),
		.push_dst  (push_dst)
	);

	lzd_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_cmd, push_src, push_dst}),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_data (q_data)
	);

	assign {q_cmd, q_src, q_dst} = q_data;

	lzd_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.WORD_BYTES   (WORD_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (q_cmd),
		.q_src        (q_src),
		.q_dst        (q_dst),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.run_last     (run_last),
		.document_end (document_end),
		.decode_status(decode_status)
	);
endmodule

// ===== design/lzd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the LZ token stream decoder, bound to the top level
module lzd_checker
	import lzd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [WORD_W-1:0]  data_word,
	input logic [COUNT_W-1:0] byte_count,
	input logic               run_last,
	input logic               document_end,
	input logic               decode_status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_word) && $stable(byte_count))
		else $error("output word changed while stalled");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && document_end |-> run_last)
		else $error("document end on a word that is not the last of its byte");

	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !document_end |-> !decode_status)
		else $error("status flagged outside document end");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count == 4'd0 |-> document_end && data_word == '0)
		else $error("empty word outside document end");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count <= 4'd8)
		else $error("byte count out of range");
endmodule

bind lz_token_stream_decoder lzd_checker u_lzd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.data_word    (data_word),
	.byte_count   (byte_count),
	.run_last     (run_last),
	.document_end (document_end),
	.decode_status(decode_status)
);

// ===== test/lz_token_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lz_token_stream_decoder: directed and random documents
module lz_token_stream_decoder_test;
	import lzd_pkg::*;

	localparam int RANDOM_BYTES = 310;
	localparam int PHASE_BYTES = 30;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		logic [WORD_W-1:0]  data;
		logic [COUNT_W-1:0] cnt;
		logic               last;
		logic               doc_end;
		logic               status;
	} word_t;

	typedef struct {
		logic [7:0] b;
		bit         fin;
	} pay_t;

	typedef enum {
		FLAW_NONE,
		FLAW_ZERO_OFFSET,
		FLAW_FAR_OFFSET,
		FLAW_OVERLONG,
		FLAW_TRUNCATE,
		FLAW_LEFTOVER,
		FLAW_NOISE
	} flaw_t;

	// Tracks decoder state and holds the words each accepted payload byte should produce
	class doc_word_predictor;
		logic [7:0]  hist [HISTORY_DEPTH_DEF];
		phase_t      phase;
		int unsigned pend;
		logic [7:0]  off_lo;
		int unsigned out_cnt;
		bit          err;
		int unsigned doc_size;
		bit          raw;
		word_t       words_due [$];
		int unsigned mismatches, words_seen, docs_closed, docs_flagged;

		function new();
			doc_size = DOC_SIZE_RESET;
			raw = 1'b0;
			clear_doc();
		endfunction

		function void clear_doc();
			phase = PH_TOKEN;
			pend = 0;
			off_lo = '0;
			out_cnt = 0;
			err = 1'b0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
			if (idx == REG_DOCUMENT_SIZE) begin
				doc_size = val & 32'h7FFF;
			end else begin
				raw = val[0];
			end
		endfunction

		function void take_byte(logic [7:0] b, bit fin);
			int unsigned lim, len, off, n, nres, wb, k, i;
			logic [7:0] made [$];
			logic [7:0] v;
			bit ok;
			word_t w;
			lim = (doc_size > HISTORY_DEPTH_DEF) ? HISTORY_DEPTH_DEF : doc_size;
			wb = WORD_BYTES_DEF;
			if (err) begin
				// silently consumed until the final byte
			end else if (raw) begin
				if (out_cnt < lim) begin
					hist[out_cnt] = b;
					out_cnt++;
					made.push_back(b);
				end else begin
					err = 1'b1;
				end
			end else begin
				case (phase)
					PH_TOKEN: begin
						if (out_cnt >= lim) begin
							err = 1'b1;
						end else if ((b & TOKEN_MATCH_BIT) != 0) begin
							pend = int'(b & TOKEN_LEN_MASK) + int'(MATCH_MIN_LEN);
							phase = PH_OFF_LO;
						end else begin
							len = int'(b) + 1;
							if (len > lim - out_cnt) begin
								err = 1'b1;
							end else begin
								pend = len;
								phase = PH_LITERAL;
							end
						end
					end
					PH_LITERAL: begin
						if (out_cnt < lim) begin
							hist[out_cnt] = b;
							out_cnt++;
							made.push_back(b);
						end
						if (pend > 0) pend--;
						if (pend == 0) phase = PH_TOKEN;
					end
					PH_OFF_LO: begin
						off_lo = b;
						phase = PH_OFF_HI;
					end
					default: begin
						off = {b, off_lo};
						if (off == 0 || off > out_cnt || pend > lim - out_cnt) begin
							err = 1'b1;
						end else begin
							for (i = 0; i < pend; i++) begin
								v = hist[out_cnt - off];
								hist[out_cnt] = v;
								out_cnt++;
								made.push_back(v);
							end
							pend = 0;
						end
						phase = PH_TOKEN;
					end
				endcase
			end

			ok = !err && phase == PH_TOKEN && out_cnt == lim;
			n = made.size();
			nres = (n + wb - 1) / wb;
			if (fin && nres == 0) nres = 1;
			for (k = 0; k < nres; k++) begin
				w.data = '0;
				w.cnt = '0;
				for (i = 0; i < wb && k * wb + i < n; i++) begin
					w.data[8*i +: 8] = made[k * wb + i];
					w.cnt++;
				end
				w.last = (k + 1 == nres);
				w.doc_end = fin && w.last;
				w.status = fin && w.last && !ok;
				words_due.push_back(w);
			end
			if (fin) begin
				docs_closed++;
				if (!ok) docs_flagged++;
				clear_doc();
			end
		endfunction

		function void check_word(logic [WORD_W-1:0] d, logic [COUNT_W-1:0] c, logic l, logic e,
				logic s);
			word_t w;
			if (words_due.size() == 0) begin
				$display("%0t: word with none due: data_word %h byte_count %0d", $time, d, c);
				mismatches++;
				return;
			end
			w = words_due.pop_front();
			words_seen++;
			if (d !== w.data) begin
				$display("%0t: data_word expected %h got %h", $time, w.data, d);
				mismatches++;
			end
			if (c !== w.cnt) begin
				$display("%0t: byte_count expected %0d got %0d", $time, w.cnt, c);
				mismatches++;
			end
			if (l !== w.last) begin
				$display("%0t: run_last expected %b got %b", $time, w.last, l);
				mismatches++;
			end
			if (e !== w.doc_end) begin
				$display("%0t: document_end expected %b got %b", $time, w.doc_end, e);
				mismatches++;
			end
			if (s !== w.status) begin
				$display("%0t: decode_status expected %b got %b", $time, w.status, s);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             code_byte;
	logic                   final_byte;
	logic                   out_valid;
	logic                   out_stall;
	logic [WORD_W-1:0]      data_word;
	logic [COUNT_W-1:0]     byte_count;
	logic                   run_last;
	logic                   document_end;
	logic                   decode_status;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DOC_SIZE_W-1:0]  cfg_data;

	doc_word_predictor pred = new();
	pay_t stream_q [$];
	int unsigned bytes_sent, settings_used, cycles;
	bit no_idle;

	// {final_byte, code_byte}
	bit [8:0] demo_words [$] = '{
		// literal run, overlapping match, two more matches fill a 40-byte document; the final token byte then flags it
		9'h002, 9'h000, 9'h0FF, 9'h05A, 9'h080, 9'h001, 9'h000,
		9'h08B, 9'h007, 9'h000, 9'h08E, 9'h016, 9'h100,
		// zero offset, then bytes swallowed until final
		9'h000, 9'h041, 9'h080, 9'h000, 9'h000, 9'h144,
		// final on a bare match token: truncated, no bytes
		9'h185,
		// literal run longer than the room left
		9'h07F, 9'h100,
		// offset reaching past the output
		9'h000, 9'h011, 9'h080, 9'h005, 9'h100
	};

	lz_token_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_byte     (code_byte),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_word     (data_word),
		.byte_count    (byte_count),
		.run_last      (run_last),
		.document_end  (document_end),
		.decode_status (decode_status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still due", cycles,
				pred.words_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			pred.check_word(data_word, byte_count, run_last, document_end, decode_status);
		out_stall <= !no_idle && ($urandom_range(0, 99) < 8);
	end

	function automatic void put(logic [7:0] b, bit fin = 1'b0);
		pay_t p;
		p.b = b;
		p.fin = fin;
		stream_q.push_back(p);
	endfunction

	task automatic send_word(logic [7:0] b, bit fin);
		no_idle = (bytes_sent >= 130 && bytes_sent < 210);
		if (!no_idle && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		pred.take_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) send_word(stream_q[i].b, stream_q[i].fin);
		stream_q.delete();
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[DOC_SIZE_W-1:0];
		pred.set_reg(idx, val);
	endtask

	task automatic set_mode(int unsigned size, bit raw);
		write_reg(REG_DOCUMENT_SIZE, size);
		write_reg(REG_RAW_MODE, raw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pred.words_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Emits a bad token at the current position; a few stray bytes may follow
	function automatic void plant_flaw(flaw_t flaw, int unsigned produced, int unsigned rem);
		int unsigned off;
		if (flaw == FLAW_OVERLONG && rem <= 127) begin
			put(8'($urandom_range(rem, 127)));
		end else if (flaw == FLAW_FAR_OFFSET) begin
			off = $urandom_range(produced + 1, 65535);
			put(TOKEN_MATCH_BIT | 8'($urandom_range(0, 127)));
			put(off[7:0]);
			put(off[15:8]);
		end else begin
			put(TOKEN_MATCH_BIT | 8'($urandom_range(0, 127)));
			put(8'h00);
			put(8'h00);
		end
		repeat ($urandom_range(0, 3)) put(8'($urandom));
	endfunction

	task automatic build_document(int unsigned size, bit raw);
		int unsigned target, produced, rem, len, cap, off, cut;
		flaw_t flaw;
		bit planted;
		if ($urandom_range(0, 9) == 0) begin
			// pure noise, final bytes anywhere
			repeat ($urandom_range(1, 6)) put(8'($urandom), $urandom_range(0, 3) == 0);
		end else begin
			target = (size > 300) ? $urandom_range(5, 120) : size;
			flaw = ($urandom_range(0, 99) < 22) ? flaw_t'($urandom_range(1, 6)) : FLAW_NONE;
			planted = !(flaw inside {FLAW_ZERO_OFFSET, FLAW_FAR_OFFSET, FLAW_OVERLONG});
			produced = 0;
			if (raw) begin
				repeat (target) put(8'($urandom));
				produced = target;
			end
			while (produced < target) begin
				rem = target - produced;
				if (!planted && $urandom_range(0, 2) == 0) begin
					plant_flaw(flaw, produced, rem);
					planted = 1'b1;
					break;
				end
				if (produced > 0 && rem >= 4 && $urandom_range(0, 1) == 1) begin
					cap = (rem > 131) ? 131 : rem;
					if ($urandom_range(0, 3) != 0 && cap > 12) cap = 12;
					len = $urandom_range(4, cap);
					cap = ($urandom_range(0, 1) == 1 && produced > 8) ? 8 : produced;
					off = $urandom_range(1, cap);
					put(TOKEN_MATCH_BIT | 8'(len - 4));
					put(off[7:0]);
					put(off[15:8]);
				end else begin
					cap = ($urandom_range(0, 9) == 0) ? 128 : 6;
					if (cap > rem) cap = rem;
					len = $urandom_range(1, cap);
					put(8'(len - 1));
					repeat (len) put(8'($urandom));
				end
				produced += len;
			end
			if (!planted) plant_flaw(flaw, produced, target - produced);
			case (flaw)
				FLAW_TRUNCATE: begin
					if (stream_q.size() > 1) begin
						cut = $urandom_range(1, stream_q.size() - 1);
						repeat (cut) void'(stream_q.pop_back());
					end
				end
				FLAW_LEFTOVER: repeat ($urandom_range(1, 2)) put(8'($urandom));
				FLAW_NOISE: stream_q[$urandom_range(0, stream_q.size() - 1)].b = 8'($urandom);
				default: ;
			endcase
		end
		stream_q[stream_q.size() - 1].fin = 1'b1;
	endtask

	initial begin
		int unsigned phase_idx, phase_bytes, size;
		bit raw;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_byte <= '0;
		final_byte <= 1'b0;
		out_stall <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cycles <= 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(40, 1'b0);
		foreach (demo_words[i]) put(demo_words[i][7:0], demo_words[i][8]);
		send_stream();
		drain();

		phase_idx = 0;
		while (bytes_sent < demo_words.size() + RANDOM_BYTES) begin
			case (phase_idx % 5)
				0: size = $urandom_range(1, 8);
				1: size = $urandom_range(9, 64);
				2: size = $urandom_range(100, 300);
				3: size = (phase_idx % 2) ? 16384 : 1;
				default: size = $urandom_range(2, 40);
			endcase
			raw = ($urandom_range(0, 3) == 0);
			if (phase_idx == 0) begin
				size = 1;
				raw = 1'b1;
			end else if (phase_idx == 1) begin
				size = 16384;
				raw = 1'b0;
			end
			set_mode(size, raw);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES &&
					bytes_sent < demo_words.size() + RANDOM_BYTES) begin
				build_document(size, raw);
				phase_bytes += stream_q.size();
				send_stream();
			end
			// leave a literal run open across the next register change
			if ($urandom_range(0, 3) == 0) begin
				put(8'h03);
				put(8'($urandom));
				send_stream();
			end
			drain();
			phase_idx++;
		end

		$display("Sent %0d payload bytes over %0d register settings; checked %0d words.",
			bytes_sent, settings_used, pred.words_seen);
		$display("Closed %0d documents, %0d of them reported as bad.",
			pred.docs_closed, pred.docs_flagged);
		if (pred.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/lzd_pkg.sv
design/lzd_ram.sv
design/lzd_fifo.sv
design/lzd_front.sv
design/lzd_back.sv
design/lz_token_stream_decoder.sv
design/lzd_checker.sv
test/lz_token_stream_decoder_test.sv
